FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CISR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define CISR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/cisr_pkg.sv
`default_nettype none
package cisr_pkg;

    localparam int COORD_W    = 32;
    localparam int RADIUS_W   = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int SQ_W       = 4 * COORD_W;
    localparam int DET_W      = 3 * COORD_W + 2;
    localparam int DABS_W     = 3 * COORD_W;
    localparam int D2_W       = 6 * COORD_W;
    localparam int ACC_W      = SQ_W + 2 * RADIUS_W;
    localparam int CMP_W      = (ACC_W + 2 > D2_W) ? ACC_W + 2 : D2_W;
    localparam int PRE_STAGES = 7;
    localparam int STAGES     = PRE_STAGES + RADIUS_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [2:0] axis_t;              // index 0 is x
    typedef logic signed [CROSS_W-1:0] cross_t;

    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t a_z;
        coord_t b_x;
        coord_t b_y;
        coord_t b_z;
        coord_t c_x;
        coord_t c_y;
        coord_t c_z;
    } cell_req_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic                degenerate;
    } radius_resp_t;

    typedef struct packed {
        cross_t [2:0]    cr;
        logic [SQ_W-1:0] sq;
    } lane_res_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [ACC_W-1:0]    p;
        logic [ACC_W-1:0]    q;
        logic [SQ_W-1:0]     smax;
        logic [D2_W-1:0]     d2;
        logic                degenerate;
    } root_t;

    function automatic logic [MAG_W-1:0] cross_mag(cross_t v);
        logic [CROSS_W-1:0] t;
        t = v[CROSS_W-1] ? (~v + 1'b1) : v;
        return t[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cell_inscribed_sphere_radius_unit.sv
`default_nettype none
// Inscribed sphere radius of a cell given by three signed Q16.16 axis vectors: half the
// smallest face separation, truncated and reported in unsigned Q16.16, with degenerate set
// and radius 0 when any cross product vanishes. Three lanes form the cross products and their
// squared lengths in parallel, the merge block forms the determinant, its square and the
// largest squared length, and a chain of 32 stages settles one radius bit each. The pipeline
// is 39 stages deep: a request is taken every cycle while the output side keeps up, and any
// empty stage lets a new request in during a stall.
module cell_inscribed_sphere_radius_unit
    import cisr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire cell_req_t s_req,
    output logic           m_valid,
    input  wire logic      m_ready,
    output radius_resp_t   m_resp
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] en;
    axis_t             axes [3];
    lane_res_t [2:0]   lane_res;
    root_t             chain [RADIUS_W+1];

    // A stage may load when the output is taken or some stage at or after it is empty.
    for (genvar i = 0; i < STAGES; i++) begin : g_en
        assign en[i] = m_ready || !(&valid_reg[STAGES-1:i]);
    end

    always_comb begin
        valid_next = valid_reg;
        if (en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign axes[0] = {s_req.a_z, s_req.a_y, s_req.a_x};
    assign axes[1] = {s_req.b_z, s_req.b_y, s_req.b_x};
    assign axes[2] = {s_req.c_z, s_req.c_y, s_req.c_x};

    for (genvar n = 0; n < 3; n++) begin : g_lane
        cisr_lane u_lane (
            .aclk (aclk),
            .en   (en[3:0]),
            .u    (axes[(n + 1) % 3]),
            .v    (axes[(n + 2) % 3]),
            .res  (lane_res[n])
        );
    end

    cisr_merge u_merge (
        .aclk  (aclk),
        .en    (en[PRE_STAGES-1:0]),
        .a     (axes[0]),
        .lanes (lane_res),
        .root  (chain[0])
    );

    for (genvar g = 0; g < RADIUS_W; g++) begin : g_root
        cisr_root_step #(
            .STEP (RADIUS_W - 1 - g)
        ) u_step (
            .aclk (aclk),
            .en   (en[PRE_STAGES + g]),
            .prev (chain[g]),
            .cur  (chain[g + 1])
        );
    end

    assign s_ready           = en[0];
    assign m_valid           = valid_reg[STAGES-1];
    assign m_resp.radius     = chain[RADIUS_W].radius;
    assign m_resp.degenerate = chain[RADIUS_W].degenerate;

endmodule
`default_nettype wire

FILE: rtl/cisr_lane.sv
`default_nettype none
module cisr_lane
    import cisr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic [3:0] en,
    input  wire axis_t     u,
    input  wire axis_t     v,
    output lane_res_t      res
);

    logic signed [PROD_W-1:0] pa_reg [3];
    logic signed [PROD_W-1:0] pb_reg [3];
    cross_t [2:0]             cr_reg;
    logic [PROD_W-1:0]        hh_reg [3];
    logic [PROD_W-1:0]        hl_reg [3];
    logic [PROD_W-1:0]        ll_reg [3];
    logic [SQ_W-1:0]          sq_reg;
    logic [MAG_W-1:0]         mag [3];
    logic [COORD_W-1:0]       mag_hi [3];
    logic [COORD_W-1:0]       mag_lo [3];
    logic [SQ_W-1:0]          sq_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k]    = cross_mag(cr_reg[k]);
            mag_hi[k] = mag[k][MAG_W-1:COORD_W];
            mag_lo[k] = mag[k][COORD_W-1:0];
        end
    end

    always_comb begin
        sq_next = '0;
        for (int k = 0; k < 3; k++) begin
            sq_next = sq_next + (SQ_W'(hh_reg[k]) << (2 * COORD_W))
                              + (SQ_W'(hl_reg[k]) << (COORD_W + 1))
                              + SQ_W'(ll_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (en[0]) begin
                pa_reg[k] <= $signed(u[(k + 1) % 3]) * $signed(v[(k + 2) % 3]);
                pb_reg[k] <= $signed(u[(k + 2) % 3]) * $signed(v[(k + 1) % 3]);
            end
            if (en[1]) begin
                cr_reg[k] <= CROSS_W'(pa_reg[k]) - CROSS_W'(pb_reg[k]);
            end
            if (en[2]) begin
                hh_reg[k] <= mag_hi[k] * mag_hi[k];
                hl_reg[k] <= mag_hi[k] * mag_lo[k];
                ll_reg[k] <= mag_lo[k] * mag_lo[k];
            end
        end
        if (en[3]) begin
            sq_reg <= sq_next;
        end
    end

    assign res.cr = cr_reg;
    assign res.sq = sq_reg;

endmodule
`default_nettype wire

FILE: rtl/cisr_merge.sv
`default_nettype none
module cisr_merge
    import cisr_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic [6:0]      en,
    input  wire axis_t           a,
    input  wire lane_res_t [2:0] lanes,
    output root_t                root
);

    axis_t              a_a_reg;
    axis_t              a_b_reg;
    logic [PROD_W-1:0]  dlo_reg [3];
    logic [PROD_W-1:0]  dhi_reg [3];
    logic [2:0]         dneg_reg;
    logic signed [DET_W-1:0] det_reg;
    logic [DABS_W-1:0]  dabs_reg;
    logic [SQ_W-1:0]    smax_e_reg;
    logic               degen_e_reg;
    logic [PROD_W-1:0]  pp_reg [3][3];
    logic [SQ_W-1:0]    smax_f_reg;
    logic               degen_f_reg;
    root_t              root_reg;

    logic [COORD_W-1:0] amag [3];
    logic [MAG_W-1:0]   cmag [3];
    logic signed [DET_W-1:0] det_sum;
    logic [DET_W-1:0]   term;
    logic [DET_W-1:0]   det_abs;
    logic [SQ_W-1:0]    smax01;
    logic [SQ_W-1:0]    smax_all;
    logic [D2_W-1:0]    d2_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            amag[k] = a_b_reg[k][COORD_W-1] ? (~a_b_reg[k] + 1'b1) : a_b_reg[k];
            cmag[k] = cross_mag(lanes[0].cr[k]);
        end
    end

    // Each term of the triple product is built from its magnitude and a sign.
    always_comb begin
        det_sum = '0;
        term    = '0;
        for (int k = 0; k < 3; k++) begin
            term = (DET_W'(dhi_reg[k]) << COORD_W) + DET_W'(dlo_reg[k]);
            if (dneg_reg[k]) begin
                det_sum = det_sum - $signed(term);
            end else begin
                det_sum = det_sum + $signed(term);
            end
        end
    end

    always_comb begin
        det_abs  = det_reg[DET_W-1] ? (~det_reg + 1'b1) : det_reg;
        smax01   = (lanes[1].sq > lanes[0].sq) ? lanes[1].sq : lanes[0].sq;
        smax_all = (lanes[2].sq > smax01) ? lanes[2].sq : smax01;
    end

    always_comb begin
        d2_sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                d2_sum = d2_sum + (D2_W'(pp_reg[i][j]) << (COORD_W * (i + j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_a_reg <= a;
        end
        if (en[1]) begin
            a_b_reg <= a_a_reg;
        end
        if (en[2]) begin
            for (int k = 0; k < 3; k++) begin
                dlo_reg[k]  <= amag[k] * cmag[k][COORD_W-1:0];
                dhi_reg[k]  <= amag[k] * cmag[k][MAG_W-1:COORD_W];
                dneg_reg[k] <= a_b_reg[k][COORD_W-1] ^ lanes[0].cr[k][CROSS_W-1];
            end
        end
        if (en[3]) begin
            det_reg <= det_sum;
        end
        if (en[4]) begin
            dabs_reg    <= det_abs[DABS_W-1:0];
            smax_e_reg  <= smax_all;
            degen_e_reg <= (lanes[0].sq == '0) || (lanes[1].sq == '0)
                        || (lanes[2].sq == '0);
        end
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    pp_reg[i][j] <= dabs_reg[COORD_W*i +: COORD_W]
                                  * dabs_reg[COORD_W*j +: COORD_W];
                end
            end
            smax_f_reg  <= smax_e_reg;
            degen_f_reg <= degen_e_reg;
        end
        if (en[6]) begin
            root_reg.radius     <= '0;
            root_reg.p          <= '0;
            root_reg.q          <= '0;
            root_reg.smax       <= smax_f_reg;
            root_reg.d2         <= d2_sum;
            root_reg.degenerate <= degen_f_reg;
        end
    end

    assign root = root_reg;

endmodule
`default_nettype wire

FILE: rtl/cisr_root_step.sv
`default_nettype none
module cisr_root_step
    import cisr_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire root_t prev,
    output root_t      cur
);

    root_t            cur_reg;
    root_t            cur_next;
    logic [ACC_W-1:0] cand_p;
    logic [ACC_W-1:0] cand_q;
    logic             take;

    // With P = r*r*smax and Q = r*smax, setting bit STEP of r adds
    // Q*2^(STEP+1) + smax*2^(2*STEP) to P, so no multiplier is needed.
    always_comb begin
        cand_p = prev.p + (prev.q << (STEP + 1)) + (ACC_W'(prev.smax) << (2 * STEP));
        cand_q = prev.q + (ACC_W'(prev.smax) << STEP);
        take   = !prev.degenerate
              && (CMP_W'({cand_p, 2'b00}) <= CMP_W'(prev.d2));
        cur_next = prev;
        if (take) begin
            cur_next.p            = cand_p;
            cur_next.q            = cand_q;
            cur_next.radius[STEP] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cur_reg <= cur_next;
        end
    end

    assign cur = cur_reg;

endmodule
`default_nettype wire

FILE: rtl/cisr_checker.sv
`default_nettype none
`include "assert_macros.svh"
module cisr_checker
    import cisr_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_valid,
    input wire logic         s_ready,
    input wire logic         m_valid,
    input wire logic         m_ready,
    input wire radius_resp_t m_resp
);

    `CISR_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result after reset")
    `CISR_ASSERT(a_resp_hold, m_valid && !m_ready |=> m_valid && $stable(m_resp), "result changed while stalled")
    `CISR_ASSERT(a_degen_zero, m_valid && m_resp.degenerate |-> m_resp.radius == '0, "degenerate cell with nonzero radius")
    `CISR_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "request refused with empty output")

endmodule

bind cell_inscribed_sphere_radius_unit cisr_checker u_cisr_checker (.*);
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
    import cisr_pkg::*;

    typedef struct {
        cell_req_t req;
        bit        drain_first;
    } pending_t;

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    cell_req_t    s_req;
    logic         m_valid;
    logic         m_ready;
    radius_resp_t m_resp;

    pending_t     pending_cells[$];
    radius_resp_t expected_radii[$];
    int           fail_count;
    int           accepted_cells;
    int           send_gap;
    int           recv_gap;
    int           long_hold;
    bit           long_hold_done;

    cell_inscribed_sphere_radius_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_resp  (m_resp)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Exact radius: the largest r with 4 * r^2 * max|cross|^2 <= det^2.
    function automatic radius_resp_t inscribed_radius(cell_req_t c);
        logic signed [259:0] ax[3][3];
        logic signed [259:0] cr[3][3];
        logic signed [259:0] det;
        logic [259:0]        sq[3];
        logic [259:0]        smax;
        logic [259:0]        d2;
        logic [259:0]        t;
        logic [31:0]         r;
        logic [31:0]         cand;
        radius_resp_t        res;
        bit                  flat;
        flat = 1'b0;
        r = '0;
        ax[0][0] = $signed(c.a_x); ax[0][1] = $signed(c.a_y); ax[0][2] = $signed(c.a_z);
        ax[1][0] = $signed(c.b_x); ax[1][1] = $signed(c.b_y); ax[1][2] = $signed(c.b_z);
        ax[2][0] = $signed(c.c_x); ax[2][1] = $signed(c.c_y); ax[2][2] = $signed(c.c_z);
        for (int n = 0; n < 3; n++) begin
            sq[n] = '0;
            for (int k = 0; k < 3; k++) begin
                cr[n][k] = ax[(n + 1) % 3][(k + 1) % 3] * ax[(n + 2) % 3][(k + 2) % 3]
                         - ax[(n + 1) % 3][(k + 2) % 3] * ax[(n + 2) % 3][(k + 1) % 3];
                sq[n] = sq[n] + $unsigned(cr[n][k] * cr[n][k]);
            end
            if (sq[n] == '0)
                flat = 1'b1;
        end
        if (!flat) begin
            det = '0;
            for (int k = 0; k < 3; k++)
                det = det + ax[0][k] * cr[0][k];
            if (det < 0)
                det = -det;
            d2 = $unsigned(det * det);
            smax = sq[0];
            for (int n = 1; n < 3; n++)
                if (sq[n] > smax)
                    smax = sq[n];
            for (int k = 31; k >= 0; k--) begin
                cand = r | (32'd1 << k);
                t = cand;
                t = t * t;
                t = t * smax;
                t = t << 2;
                if (t <= d2)
                    r = cand;
            end
        end
        res.radius = r;
        res.degenerate = flat;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_cells.size() > 0 &&
                         !(pending_cells[0].drain_first &&
                           (expected_radii.size() > 0 || s_valid))) begin
                s_req <= pending_cells[0].req;
                s_valid <= 1'b1;
                void'(pending_cells.pop_front());
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random back-pressure plus one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
            long_hold <= 0;
            long_hold_done <= 1'b0;
        end else if (!long_hold_done && accepted_cells >= 300) begin
            long_hold_done <= 1'b1;
            long_hold <= 200;
            m_ready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            m_ready <= (long_hold == 1);
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= (recv_gap == 1);
        end else begin
            recv_gap <= pick_gap();
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge aclk) begin
        radius_resp_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_radii.push_back(inscribed_radius(s_req));
                accepted_cells++;
            end
            if (m_valid && m_ready) begin
                if (expected_radii.size() == 0) begin
                    report_mismatch("unexpected result", m_resp.radius, '0);
                end else begin
                    want = expected_radii.pop_front();
                    if (m_resp.radius !== want.radius)
                        report_mismatch("radius", m_resp.radius, want.radius);
                    if (m_resp.degenerate !== want.degenerate)
                        report_mismatch("degenerate", 32'(m_resp.degenerate),
                                        32'(want.degenerate));
                end
            end
        end
    end

    task automatic queue_cell(cell_req_t c, bit drain);
        pending_t p;
        p.req = c;
        p.drain_first = drain;
        pending_cells.push_back(p);
    endtask

    function automatic cell_req_t diag_cell(coord_t x, coord_t y, coord_t z);
        cell_req_t c;
        c = '0;
        c.a_x = x;
        c.b_y = y;
        c.c_z = z;
        return c;
    endfunction

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            default: return coord_t'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic cell_req_t random_cell();
        cell_req_t c;
        int        mode;
        int        kind;
        mode = $urandom_range(2);
        kind = $urandom_range(99);
        c.a_x = rand_coord(mode); c.a_y = rand_coord(mode); c.a_z = rand_coord(mode);
        c.b_x = rand_coord(mode); c.b_y = rand_coord(mode); c.b_z = rand_coord(mode);
        c.c_x = rand_coord(mode); c.c_y = rand_coord(mode); c.c_z = rand_coord(mode);
        if (kind < 50) begin
            // Box-like cell: diagonal redrawn in 1.0 to 256.0, off-diagonal shear left random.
            c.a_x = coord_t'($urandom_range(32'h0001_0000, 32'h0100_0000));
            c.b_y = coord_t'($urandom_range(32'h0001_0000, 32'h0100_0000));
            c.c_z = coord_t'($urandom_range(32'h0001_0000, 32'h0100_0000));
            if ($urandom_range(1)) c.a_x = -c.a_x;
        end else if (kind < 58) begin
            c.b_x = c.a_x; c.b_y = c.a_y; c.b_z = c.a_z;
        end else if (kind < 62) begin
            c.c_x = c.b_x; c.c_y = c.b_y; c.c_z = c.b_z;
        end
        return c;
    endfunction

    initial begin
        cell_req_t c;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req = '0;
        m_ready = 1'b0;
        fail_count = 0;
        accepted_cells = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero cell, cubes, extremes, collinear and coplanar axes, skewed cell.
        queue_cell('0, 1'b0);
        queue_cell(diag_cell(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000), 1'b0);
        queue_cell(diag_cell(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 1'b0);
        queue_cell(diag_cell(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 1'b0);
        queue_cell(diag_cell(32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh7FFF_FFFF), 1'b0);
        queue_cell(diag_cell(-32'sd1, -32'sd1, -32'sd1), 1'b0);
        queue_cell(diag_cell(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001), 1'b0);
        queue_cell(diag_cell(32'sh0003_0000, 32'sh0001_0000, 32'sh0005_0000), 1'b0);
        c = '1;
        queue_cell(c, 1'b0);
        c = {9{32'sh7FFF_FFFF}};
        queue_cell(c, 1'b0);
        c = {9{32'sh8000_0000}};
        queue_cell(c, 1'b0);
        c = diag_cell(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        c.b_x = 32'sh0001_0000;
        c.b_y = '0;
        queue_cell(c, 1'b0);
        c = diag_cell(32'sh0002_0000, 32'sh0002_0000, '0);
        queue_cell(c, 1'b0);
        c = diag_cell(32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000);
        c.b_x = 32'sh0002_0000;
        c.c_x = 32'sh0002_0000;
        c.c_y = 32'sh0002_0000;
        queue_cell(c, 1'b0);
        c = diag_cell(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        c.a_y = 32'sh8000_0000;
        c.b_z = 32'sh7FFF_FFFF;
        c.c_x = 32'sh8000_0000;
        queue_cell(c, 1'b0);

        for (int i = 0; i < 700; i++)
            queue_cell(random_cell(), (i == 450));

        while (pending_cells.size() > 0 || expected_radii.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && expected_radii.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
